FILE: sv/lap3x3_pkg.sv
// Shared types and constants for the 3x3 Laplacian filter core.
// No dependencies; every other file of the block but the line store refers to this package.
`timescale 1ns / 1ps

package lap3x3_pkg;

	// Default capacity of the line stores, in pixels per row.
	localparam int MaxWidth = 1024;

	// Field widths fixed by the interface.
	localparam int PixelBits = 8;
	localparam int LapBits = 12;
	localparam int FwBits = 11;
	localparam int FhBits = 13;
	localparam int CfgBits = 13;

	// Row counters: the input row runs up to one past the frame height while draining.
	localparam int InRowBits = 13;
	localparam int OutRowBits = 12;

	// Register limits and reset values.
	localparam int HeightLimit = 4096;
	localparam int WidthReset = 1024;
	localparam int HeightReset = 1024;

	// Result queue depth, which also sets how many items may be in flight.
	localparam int FifoDepth = 4;

	// Configuration register indexes.
	typedef enum logic {
		RegFrameWidth,
		RegFrameHeight
	} cfg_reg_t;

	typedef logic [PixelBits-1:0] pix_t;

	// One window column: index 0 is the upper row, index 2 the lower row.
	typedef pix_t [2:0] pix_col_t;

	typedef struct packed {
		logic req_type;
		pix_t pixel;
	} in_item_t;

	typedef struct packed {
		logic signed [LapBits-1:0] laplacian;
		logic                      frame_last;
	} out_item_t;

endpackage

FILE: sv/lap3x3_line_store.sv
// Single line store: one write port and one read port with registered read data.
// Depends on nothing; widths come from the instance parameters.
`timescale 1ns / 1ps

module lap3x3_line_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data_q,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/lap3x3_col_cell.sv
// One cell of the window chain: holds a three-pixel column and passes it on.
// Depends on lap3x3_pkg for the column type.
`timescale 1ns / 1ps

module lap3x3_col_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift_en,
	input  lap3x3_pkg::pix_col_t col_in,
	output lap3x3_pkg::pix_col_t col_q
);

	// The column moves one place along the chain with every active item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

endmodule

FILE: sv/lap3x3_out_fifo.sv
// Small result queue that decouples the filter pipeline from the output handshake.
// Depends on lap3x3_pkg for the result item type.
`timescale 1ns / 1ps

module lap3x3_out_fifo #(
	parameter int DEPTH = lap3x3_pkg::FifoDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  lap3x3_pkg::out_item_t      push_item,
	input  logic                       pop,
	output logic [$clog2(DEPTH+1)-1:0] fill,
	output logic                       valid,
	output lap3x3_pkg::out_item_t      item
);

	localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntBits = $clog2(DEPTH+1);

	lap3x3_pkg::out_item_t store_q [DEPTH];
	logic [PtrBits-1:0]    wr_ptr_q;
	logic [PtrBits-1:0]    rd_ptr_q;
	logic [CntBits-1:0]    fill_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PtrBits'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PtrBits'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + CntBits'(1);
				2'b01:   fill_q <= fill_q - CntBits'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	assign fill  = fill_q;
	assign valid = (fill_q != '0);
	assign item  = store_q[rd_ptr_q];

endmodule

FILE: sv/laplacian_3x3_filter_core.sv
// Pipeline: the result of the item that completes a neighborhood is registered in stage 1
// and stage 2, then queued; that item comes frame_width + 1 positions after the pixel.
// Throughput: one item per cycle, limited by the four-entry result queue credit.
// Reset: counters, window cells, pipeline and queue are cleared; registers return to
// 1024 x 1024; the line stores are not cleared and take no clearing pass.
`timescale 1ns / 1ps

module laplacian_3x3_filter_core #(
	parameter int MAX_WIDTH = lap3x3_pkg::MaxWidth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  lap3x3_pkg::in_item_t              pix_item,
	output logic                              res_valid,
	input  logic                              res_ready,
	output lap3x3_pkg::out_item_t             res_item,
	input  logic                              cfg_we,
	input  lap3x3_pkg::cfg_reg_t              cfg_index,
	input  logic [lap3x3_pkg::CfgBits-1:0]    cfg_data
);

	localparam int ColBits = $clog2(MAX_WIDTH);
	localparam int FwBits = lap3x3_pkg::FwBits;
	localparam int FhBits = lap3x3_pkg::FhBits;
	localparam int InRowBits = lap3x3_pkg::InRowBits;
	localparam int OutRowBits = lap3x3_pkg::OutRowBits;
	localparam int PixelBits = lap3x3_pkg::PixelBits;
	localparam int LapBits = lap3x3_pkg::LapBits;
	localparam int FifoDepth = lap3x3_pkg::FifoDepth;
	localparam int FillBits = $clog2(FifoDepth + 1);
	localparam int NumCells = 2;
	localparam int WidthResetEff =
		(lap3x3_pkg::WidthReset > MAX_WIDTH) ? MAX_WIDTH : lap3x3_pkg::WidthReset;

	typedef struct packed {
		logic top_out;
		logic bot_out;
		logic left_out;
		logic right_out;
	} mask_t;

	// Sum of one column with the rows outside the frame left out.
	function automatic logic [9:0] col_sum(lap3x3_pkg::pix_col_t col, logic top_out,
		logic bot_out);
		logic [9:0] s;
		s = 10'(top_out ? '0 : col[0]) + 10'(col[1]) + 10'(bot_out ? '0 : col[2]);
		return s;
	endfunction

	// Registers and position counters.
	logic [FwBits-1:0]     w_q;
	logic [FhBits-1:0]     h_q;
	logic [ColBits-1:0]    in_col_q;
	logic [InRowBits-1:0]  in_row_q;
	logic [ColBits-1:0]    out_col_q;
	logic [OutRowBits-1:0] out_row_q;

	// Stage 1: item after acceptance, line store data arriving.
	logic                  valid_s1;
	logic                  emit_s1;
	lap3x3_pkg::pix_t      p_s1;
	logic [ColBits-1:0]    addr_s1;
	logic                  up_en_s1;
	logic                  mid_en_s1;
	mask_t                 mask_s1;
	logic                  last_s1;
	logic                  byp_s1;
	lap3x3_pkg::pix_t      byp_up_s1;
	lap3x3_pkg::pix_t      byp_mid_s1;

	// Stage 2: partial sums of the neighborhood.
	logic                  valid_s2;
	logic [9:0]            nb_l_s2;
	logic [9:0]            nb_r_s2;
	logic [8:0]            nb_c_s2;
	lap3x3_pkg::pix_t      ctr_s2;
	logic                  last_s2;

	// Front-end decode of the offered item.
	logic                  accept;
	logic                  flush;
	logic                  in_frame;
	logic                  act;
	lap3x3_pkg::pix_t      p0;
	logic                  emit0;
	logic                  in_col_wrap;
	logic                  out_col_end;
	logic                  out_row_end;
	logic                  last0;
	mask_t                 mask0;
	logic [FwBits-1:0]     cfg_w;
	logic [FhBits-1:0]     cfg_h;

	lap3x3_pkg::pix_t      up_rd;
	lap3x3_pkg::pix_t      mid_rd;
	lap3x3_pkg::pix_t      up1;
	lap3x3_pkg::pix_t      mid1;
	lap3x3_pkg::pix_col_t  new_col;
	lap3x3_pkg::pix_col_t  cell_in [NumCells];
	lap3x3_pkg::pix_col_t  cell_q [NumCells];
	lap3x3_pkg::pix_col_t  lc;
	lap3x3_pkg::pix_col_t  cc;
	logic [9:0]            nb_l;
	logic [9:0]            nb_r;
	logic [8:0]            nb_c;

	logic [LapBits-1:0]    nb_total;
	lap3x3_pkg::out_item_t push_item;
	logic [FillBits-1:0]   fill;

	// Item decode: flushes inside the frame are dropped, late pixels count as zero.
	always_comb begin
		accept      = pix_valid && pix_ready;
		flush       = pix_item.req_type;
		in_frame    = (in_row_q < InRowBits'(h_q));
		act         = accept && !(flush && in_frame);
		p0          = (!flush && in_frame) ? pix_item.pixel : '0;
		emit0       = (in_row_q >= InRowBits'(2)) ||
			((in_row_q == InRowBits'(1)) && (in_col_q != '0));
		in_col_wrap = (int'(in_col_q) + 1) >= int'(w_q);
		out_col_end = (int'(out_col_q) + 1) >= int'(w_q);
		out_row_end = (int'(out_row_q) + 1) >= int'(h_q);
		last0       = out_row_end && out_col_end;
		mask0.top_out   = (out_row_q == '0);
		mask0.bot_out   = out_row_end;
		mask0.left_out  = (out_col_q == '0);
		mask0.right_out = (in_col_q == '0) || out_col_end;
	end

	// Clamp written register values into their working ranges.
	always_comb begin
		cfg_w = cfg_data[FwBits-1:0];
		if (cfg_w == '0) begin
			cfg_w = FwBits'(1);
		end else if (int'(cfg_w) > MAX_WIDTH) begin
			cfg_w = FwBits'(MAX_WIDTH);
		end
		cfg_h = cfg_data[FhBits-1:0];
		if (cfg_h == '0) begin
			cfg_h = FhBits'(1);
		end else if (int'(cfg_h) > lap3x3_pkg::HeightLimit) begin
			cfg_h = FhBits'(lap3x3_pkg::HeightLimit);
		end
	end

	// Registers and raster counters; any register write starts a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= FwBits'(WidthResetEff);
			h_q       <= FhBits'(lap3x3_pkg::HeightReset);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lap3x3_pkg::RegFrameWidth:  w_q <= cfg_w;
				lap3x3_pkg::RegFrameHeight: h_q <= cfg_h;
				default:                    w_q <= w_q;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (act) begin
			if (emit0 && last0) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_col_wrap ? '0 : in_col_q + ColBits'(1);
				if (in_col_wrap) begin
					in_row_q <= in_row_q + InRowBits'(1);
				end
				if (emit0) begin
					out_col_q <= out_col_end ? '0 : out_col_q + ColBits'(1);
					if (out_col_end) begin
						out_row_q <= out_row_q + OutRowBits'(1);
					end
				end
			end
		end
	end

	// Line stores: upper holds the row two above, middle the row above.
	lap3x3_line_store #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(PixelBits)
	) u_upper_line (
		.clk      (clk),
		.rd_en    (act),
		.rd_addr  (in_col_q),
		.rd_data_q(up_rd),
		.wr_en    (valid_s1),
		.wr_addr  (addr_s1),
		.wr_data  (mid1)
	);

	lap3x3_line_store #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(PixelBits)
	) u_middle_line (
		.clk      (clk),
		.rd_en    (act),
		.rd_addr  (in_col_q),
		.rd_data_q(mid_rd),
		.wr_en    (valid_s1),
		.wr_addr  (addr_s1),
		.wr_data  (p_s1)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= act;
			emit_s1  <= act && emit0;
			// A read of the column being written this cycle takes the new data.
			byp_s1   <= act && valid_s1 && (addr_s1 == in_col_q);
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (act) begin
			p_s1       <= p0;
			addr_s1    <= in_col_q;
			up_en_s1   <= (in_row_q >= InRowBits'(2));
			mid_en_s1  <= (in_row_q != '0);
			mask_s1    <= mask0;
			last_s1    <= last0;
			byp_up_s1  <= mid1;
			byp_mid_s1 <= p_s1;
		end
	end

	// New column: rows above the frame enter as zero.
	always_comb begin
		up1        = up_en_s1 ? (byp_s1 ? byp_up_s1 : up_rd) : '0;
		mid1       = mid_en_s1 ? (byp_s1 ? byp_mid_s1 : mid_rd) : '0;
		new_col[0] = up1;
		new_col[1] = mid1;
		new_col[2] = p_s1;
	end

	// Window chain: cell 0 holds the newest column, cell 1 the one before it.
	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign cell_in[k] = new_col;
		end else begin : g_tail
			assign cell_in[k] = cell_q[k-1];
		end
		lap3x3_col_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(valid_s1),
			.col_in  (cell_in[k]),
			.col_q   (cell_q[k])
		);
	end

	// Column sums of the neighborhood with the frame border masked.
	always_comb begin
		lc   = cell_q[1];
		cc   = cell_q[0];
		nb_l = mask_s1.left_out ? '0 : col_sum(lc, mask_s1.top_out, mask_s1.bot_out);
		nb_r = mask_s1.right_out ? '0 :
			col_sum(new_col, mask_s1.top_out, mask_s1.bot_out);
		nb_c = 9'(mask_s1.top_out ? '0 : cc[0]) + 9'(mask_s1.bot_out ? '0 : cc[2]);
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && emit_s1) begin
			nb_l_s2 <= nb_l;
			nb_r_s2 <= nb_r;
			nb_c_s2 <= nb_c;
			ctr_s2  <= cc[1];
			last_s2 <= last_s1;
		end
	end

	// Eight times the center minus the neighbor sum.
	always_comb begin
		nb_total = LapBits'(nb_l_s2) + LapBits'(nb_r_s2) + LapBits'(nb_c_s2);
		push_item.laplacian  = signed'(LapBits'({1'b0, ctr_s2, 3'b000}) - nb_total);
		push_item.frame_last = last_s2;
	end

	lap3x3_out_fifo #(
		.DEPTH(FifoDepth)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s2),
		.push_item(push_item),
		.pop      (res_valid && res_ready),
		.fill     (fill),
		.valid    (res_valid),
		.item     (res_item)
	);

	// Accept only while the queue has room for every result still in flight.
	assign pix_ready = ((FillBits+1)'(fill) + (FillBits+1)'(valid_s1 && emit_s1) +
		(FillBits+1)'(valid_s2)) < (FillBits+1)'(FifoDepth);

endmodule

FILE: tb/tb_laplacian_3x3_filter_core.sv
// Self-checking testbench for laplacian_3x3_filter_core: directed and random raster frames,
// with an internal predictor of the eight-neighbor Laplacian and an in-order scoreboard.
// Depends on lap3x3_pkg and the filter core; reads no files.
`timescale 1ns / 1ps

module tb_laplacian_3x3_filter_core;
	import lap3x3_pkg::*;

	localparam int ClkPeriod = 4;
	localparam int ResetCycles = 5;
	localparam int IdlePct = 29;
	localparam int SettleCycles = 8;
	localparam int TailCycles = 16;
	localparam int CycleLimit = 1000000;
	localparam int RandomItems = 1600;
	localparam int CalmFrom = 700;
	localparam int CalmTo = 1100;
	localparam logic ReqPixel = 1'b0;
	localparam logic ReqFlush = 1'b1;

	typedef enum {
		StepItem,
		StepRegWrite,
		StepHold
	} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		in_item_t             item;
		cfg_reg_t             reg_sel;
		logic [CfgBits-1:0]   value;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 pix_valid = 1'b0;
	logic                 pix_ready;
	in_item_t             pix_item = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	out_item_t            res_item;
	logic                 cfg_we = 1'b0;
	cfg_reg_t             cfg_index = RegFrameWidth;
	logic [CfgBits-1:0]   cfg_data = '0;

	laplacian_3x3_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_item  (pix_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock and cycle count.
	always #(ClkPeriod / 2) clk = ~clk;

	int cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Stimulus steps waiting for the driver, and results still owed by the block.
	step_t     step_q[$];
	out_item_t lap_expect_q[$];
	int        items_sent = 0;
	int        built_items = 0;
	int        settle_cnt = 0;
	int        err_cnt = 0;
	logic      calm;

	assign calm = (items_sent >= CalmFrom) && (items_sent < CalmTo);

	// Predictor state: line stores, neighborhood window, raster positions, geometry.
	pix_t row_above_mem [MaxWidth];
	pix_t row_prev_mem [MaxWidth];
	pix_t nbhd [3][3] = '{default: '0};
	int   in_col = 0;
	int   in_row = 0;
	int   out_col = 0;
	int   out_row = 0;
	int   frame_w = WidthReset;
	int   frame_h = HeightReset;

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Register write as the block sees it: out-of-range sizes are clamped, and
	// any write starts a new frame.
	function automatic void load_geometry(cfg_reg_t sel, logic [CfgBits-1:0] value);
		int v;
		if (sel == RegFrameWidth) begin
			v = int'(value[FwBits-1:0]);
			if (v == 0) v = 1;
			if (v > MaxWidth) v = MaxWidth;
			frame_w = v;
		end else begin
			v = int'(value[FhBits-1:0]);
			if (v == 0) v = 1;
			if (v > HeightLimit) v = HeightLimit;
			frame_h = v;
		end
		restart_frame();
	endfunction

	// Eight times the center minus the neighbors that lie inside the frame.
	function automatic int masked_laplacian(pix_col_t lc, pix_col_t cc, pix_col_t rc,
			bit top_out, bit bot_out, bit left_out, bit right_out);
		int acc;
		acc = 0;
		for (int r = 0; r < 3; r++) begin
			if ((r == 0 && top_out) || (r == 2 && bot_out)) continue;
			if (!left_out) acc = acc - int'(lc[r]);
			if (!right_out) acc = acc - int'(rc[r]);
			if (r != 1) acc = acc - int'(cc[r]);
		end
		return acc + 8 * int'(cc[1]);
	endfunction

	// Advance the predictor by one accepted item and queue the result it causes.
	task automatic predict_laplacian(in_item_t it);
		bit        flush;
		bit        emit;
		bit        last;
		int        c;
		int        val;
		pix_t      up;
		pix_t      mid;
		pix_t      p;
		pix_col_t  lc;
		pix_col_t  cc;
		pix_col_t  rc;
		out_item_t res;
		flush = (it.req_type == ReqFlush);
		// A flush inside the frame does nothing.
		if (flush && in_row < frame_h) return;
		// Past the last row every item feeds zero, whatever it carries.
		p = (!flush && in_row < frame_h) ? it.pixel : '0;
		c = in_col;
		if (c >= MaxWidth) c = 0;

		up = (in_row >= 2) ? row_above_mem[c] : '0;
		mid = (in_row >= 1) ? row_prev_mem[c] : '0;
		row_above_mem[c] = mid;
		row_prev_mem[c] = p;

		emit = (in_row >= 2) || (in_row == 1 && c >= 1);
		val = 0;

		// At column zero the pending output closes the previous row.
		if (emit && c == 0) begin
			for (int r = 0; r < 3; r++) begin
				lc[r] = nbhd[r][1];
				cc[r] = nbhd[r][2];
				rc[r] = '0;
			end
			val = masked_laplacian(lc, cc, rc, out_row == 0, out_row + 1 >= frame_h,
				out_col == 0, 1'b1);
		end

		for (int r = 0; r < 3; r++) begin
			nbhd[r][0] = nbhd[r][1];
			nbhd[r][1] = nbhd[r][2];
		end
		nbhd[0][2] = up;
		nbhd[1][2] = mid;
		nbhd[2][2] = p;

		if (emit && c != 0) begin
			for (int r = 0; r < 3; r++) begin
				lc[r] = nbhd[r][0];
				cc[r] = nbhd[r][1];
				rc[r] = nbhd[r][2];
			end
			val = masked_laplacian(lc, cc, rc, out_row == 0, out_row + 1 >= frame_h,
				out_col == 0, out_col + 1 >= frame_w);
		end

		in_col = c + 1;
		if (in_col >= frame_w) begin
			in_col = 0;
			in_row++;
		end

		if (!emit) return;

		last = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
		res.laplacian = val[LapBits-1:0];
		res.frame_last = last;
		lap_expect_q.push_back(res);

		out_col++;
		if (out_col >= frame_w) begin
			out_col = 0;
			out_row++;
		end
		if (last) restart_frame();
	endtask

	// Stimulus builders.
	task automatic queue_item(logic rtype, pix_t value);
		step_t s;
		s.kind = StepItem;
		s.item.req_type = rtype;
		s.item.pixel = value;
		s.reg_sel = RegFrameWidth;
		s.value = '0;
		step_q.push_back(s);
		built_items++;
	endtask

	task automatic queue_reg(cfg_reg_t sel, int value);
		step_t s;
		s.kind = StepRegWrite;
		s.item = '0;
		s.reg_sel = sel;
		s.value = value[CfgBits-1:0];
		step_q.push_back(s);
	endtask

	task automatic queue_hold();
		step_t s;
		s.kind = StepHold;
		s.item = '0;
		s.reg_sel = RegFrameWidth;
		s.value = '0;
		step_q.push_back(s);
	endtask

	// One frame of w x h pixels with scattered ignored flushes, then the drain items.
	// A broken frame stops early and is abandoned by the next register write.
	task automatic queue_frame(int w, int h, bit broken);
		int npix;
		int style;
		pix_t v;
		npix = w * h;
		if (broken) npix = $urandom_range(0, npix - 1);
		style = $urandom_range(0, 9);
		for (int k = 0; k < npix; k++) begin
			if ($urandom_range(0, 24) == 0) queue_item(ReqFlush, pix_t'($urandom));
			if ($urandom_range(0, 199) == 0) queue_hold();
			if (style < 6) v = pix_t'($urandom);
			else if (style < 8) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else v = ($urandom_range(0, 11) == 0) ? 8'hFF : 8'h00;
			queue_item(ReqPixel, v);
		end
		if (broken) return;
		// Drain: flush ticks or pixels beyond the frame, which act the same.
		for (int k = 0; k <= w; k++)
			queue_item($urandom_range(0, 1) ? ReqFlush : ReqPixel, pix_t'($urandom));
		if ($urandom_range(0, 4) == 0) queue_item(ReqFlush, pix_t'($urandom));
	endtask

	// Driver: one item offered at a time; register writes and holds wait for an idle block.
	always @(posedge clk) begin : drive_proc
		logic  nxt_valid;
		logic  nxt_we;
		step_t head;
		if (arst_n) begin
			if (pix_valid && pix_ready) predict_laplacian(pix_item);
			nxt_we = 1'b0;
			nxt_valid = pix_valid && !pix_ready;
			if (!nxt_valid && step_q.size() > 0) begin
				head = step_q[0];
				if (head.kind == StepItem) begin
					settle_cnt = 0;
					if (calm || $urandom_range(0, 99) >= IdlePct) begin
						pix_item <= head.item;
						nxt_valid = 1'b1;
						void'(step_q.pop_front());
						items_sent++;
					end
				end else if (lap_expect_q.size() != 0 || cfg_we) begin
					settle_cnt = 0;
				end else if (settle_cnt < SettleCycles) begin
					settle_cnt++;
				end else begin
					settle_cnt = 0;
					void'(step_q.pop_front());
					if (head.kind == StepRegWrite) begin
						nxt_we = 1'b1;
						cfg_index <= head.reg_sel;
						cfg_data <= head.value;
						load_geometry(head.reg_sel, head.value);
					end
				end
			end
			pix_valid <= nxt_valid;
			cfg_we <= nxt_we;
		end
	end

	// Monitor: every result is checked against the oldest expected one.
	always @(posedge clk) begin : check_proc
		out_item_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (lap_expect_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result: expected none, actual laplacian %0d last %0b",
						$time, res_item.laplacian, res_item.frame_last);
				end else begin
					want = lap_expect_q.pop_front();
					if (res_item.laplacian !== want.laplacian) begin
						err_cnt++;
						$display("%0t: laplacian mismatch: expected %0d, actual %0d",
							$time, want.laplacian, res_item.laplacian);
					end
					if (res_item.frame_last !== want.frame_last) begin
						err_cnt++;
						$display("%0t: frame_last mismatch: expected %0b, actual %0b",
							$time, want.frame_last, res_item.frame_last);
					end
				end
			end
			res_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
		end
	end

	// Watchdog.
	initial begin
		wait (cycle_cnt >= CycleLimit);
		$display("RESULT: ERROR");
		$finish;
	end

	// Stimulus plan, reset and end of run.
	initial begin : main_proc
		int w;
		int h;
		int wdata;
		int hdata;
		int nframes;
		int random_start;
		bit new_w;
		bit new_h;
		bit broken;

		// Default 1024 x 1024 geometry: two pixels and an ignored flush, then abandoned.
		queue_item(ReqPixel, 8'h00);
		queue_item(ReqFlush, 8'hFF);
		queue_item(ReqPixel, 8'hFF);
		queue_reg(RegFrameWidth, 3);
		queue_reg(RegFrameHeight, 3);
		// Bright center on black: the largest positive value.
		for (int k = 0; k < 9; k++) queue_item(ReqPixel, (k == 4) ? 8'hFF : 8'h00);
		for (int k = 0; k < 4; k++) queue_item(ReqFlush, 8'h00);
		queue_hold();
		// Dark center on white: the most negative value, drained by pixels past the frame.
		for (int k = 0; k < 9; k++) queue_item(ReqPixel, (k == 4) ? 8'h00 : 8'hFF);
		for (int k = 0; k < 4; k++) queue_item(ReqPixel, 8'hA5);

		// Register extremes: zero sizes, oversized values, bits above the width field.
		queue_reg(RegFrameWidth, 0);
		queue_reg(RegFrameHeight, 0);
		queue_frame(1, 1, 1'b0);
		queue_reg(RegFrameWidth, 2047);
		queue_reg(RegFrameHeight, 8191);
		// Oversized geometry: the start of a frame, abandoned by the next write.
		for (int k = 0; k < 6; k++) queue_item(ReqPixel, pix_t'($urandom));
		queue_reg(RegFrameHeight, 2);
		queue_reg(RegFrameWidth, 13'h0803);
		queue_frame(3, 2, 1'b0);
		w = 3;
		h = 2;

		// Random phases: new geometry, then one to three frames.
		random_start = built_items;
		while (built_items < random_start + RandomItems) begin
			new_w = 1'b0;
			new_h = 1'b0;
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: w = $urandom_range(1, 8);
					5, 6, 7, 8: w = $urandom_range(9, 40);
					default: w = $urandom_range(41, 160);
				endcase
				new_w = 1'b1;
			end
			if ($urandom_range(0, 3) != 0 || !new_w) begin
				h = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				new_h = 1'b1;
			end
			if (w * h > 480) begin
				h = (480 / w > 0) ? 480 / w : 1;
				new_h = 1'b1;
			end
			wdata = (w == 1 && $urandom_range(0, 2) == 0) ? 0 : w;
			if ($urandom_range(0, 7) == 0) wdata = wdata | ($urandom_range(1, 3) << FwBits);
			hdata = (h == 1 && $urandom_range(0, 2) == 0) ? 0 : h;
			if ($urandom_range(0, 1) == 0) begin
				if (new_w) queue_reg(RegFrameWidth, wdata);
				if (new_h) queue_reg(RegFrameHeight, hdata);
			end else begin
				if (new_h) queue_reg(RegFrameHeight, hdata);
				if (new_w) queue_reg(RegFrameWidth, wdata);
			end
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				broken = (f == nframes - 1) && ($urandom_range(0, 9) == 0);
				queue_frame(w, h, broken);
			end
			if ($urandom_range(0, 5) == 0) queue_hold();
		end

		// Reset once, then let the driver run the plan.
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (step_q.size() != 0 || pix_valid || cfg_we || lap_expect_q.size() != 0);
		repeat (TailCycles) @(posedge clk);

		if (err_cnt == 0 && lap_expect_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
